// ===== hw/rtl/gcp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types, constants and helpers for the great circle path point block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcp_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANG_SHIFT       = 24 - ANGLE_FRAC_BITS;
    localparam int CORDIC_ITERS    = 24;

    typedef logic signed [33:0] t_dat;
    typedef logic signed [33:0] t_ang;
    typedef logic signed [31:0] t_mix;
    typedef logic signed [17:0] t_vec;

    localparam t_ang HALF_Q24    = 34'sd3019898880;
    localparam t_ang QUARTER_Q24 = 34'sd1509949440;
    localparam t_ang FULL_Q24    = 34'sd6039797760;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    localparam logic signed [25:0] LON_LIM = 26'sd11796480;
    localparam logic signed [25:0] LAT_LIM = 26'sd5898240;

    localparam logic [1:0] SLOT_FROM_LAT = 2'd0;
    localparam logic [1:0] SLOT_FROM_LON = 2'd1;
    localparam logic [1:0] SLOT_TO_LAT   = 2'd2;
    localparam logic [1:0] SLOT_TO_LON   = 2'd3;

    typedef struct packed {
        logic       neg;
        logic [1:0] slot;
    } t_sc_tag;

    function automatic t_ang atan_deg(input int unsigned idx);
        t_ang r;
        unique case (idx)
            0:  r = 34'sd754974720;
            1:  r = 34'sd445687602;
            2:  r = 34'sd235489088;
            3:  r = 34'sd119537938;
            4:  r = 34'sd60000934;
            5:  r = 34'sd30029717;
            6:  r = 34'sd15018523;
            7:  r = 34'sd7509720;
            8:  r = 34'sd3754917;
            9:  r = 34'sd1877466;
            10: r = 34'sd938734;
            11: r = 34'sd469367;
            12: r = 34'sd234684;
            13: r = 34'sd117342;
            14: r = 34'sd58671;
            15: r = 34'sd29336;
            16: r = 34'sd14668;
            17: r = 34'sd7334;
            18: r = 34'sd3667;
            19: r = 34'sd1833;
            20: r = 34'sd917;
            21: r = 34'sd458;
            22: r = 34'sd229;
            23: r = 34'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [25:0] q24_round(input t_ang z);
        t_ang s;
        s = z + t_ang'(1 << (ANG_SHIFT - 1));
        return 26'(s >>> ANG_SHIFT);
    endfunction

    function automatic logic signed [24:0] to_lon(input t_ang z);
        logic signed [25:0] v;
        v = q24_round(z);
        if (v > LON_LIM) v = LON_LIM;
        if (v < -LON_LIM) v = -LON_LIM;
        return 25'(v);
    endfunction

    function automatic logic signed [23:0] to_lat(input t_ang z);
        logic signed [25:0] v;
        v = q24_round(z);
        if (v > LAT_LIM) v = LAT_LIM;
        if (v < -LAT_LIM) v = -LAT_LIM;
        return 24'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// gcp_cordic_cell
// One registered CORDIC iteration, rotation or vectoring, with a side tag.
// ----------------------------------------------------------------------------
`default_nettype none

module gcp_cordic_cell #(
    parameter int ITER      = 0,
    parameter bit VECTORING = 1'b0,
    parameter int TAG_W     = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire gcp_pkg::t_dat      i_x,
    input  wire gcp_pkg::t_dat      i_y,
    input  wire gcp_pkg::t_ang      i_z,
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_valid,
    output gcp_pkg::t_dat           o_x,
    output gcp_pkg::t_dat           o_y,
    output gcp_pkg::t_ang           o_z,
    output logic [TAG_W-1:0]        o_tag
);
    import gcp_pkg::*;

    localparam t_ang STEP_ANG = atan_deg(ITER);

    logic             r_valid;
    t_dat             r_x, r_y, n_x, n_y;
    t_ang             r_z, n_z;
    logic [TAG_W-1:0] r_tag;
    t_dat             xs, ys;

    assign xs = i_x >>> ITER;
    assign ys = i_y >>> ITER;

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (VECTORING) begin
            if (i_y > 0) begin
                n_x = i_x + ys;
                n_y = i_y - xs;
                n_z = i_z + STEP_ANG;
            end else if (i_y < 0) begin
                n_x = i_x - ys;
                n_y = i_y + xs;
                n_z = i_z - STEP_ANG;
            end
        end else begin
            if (i_z >= 0) begin
                n_x = i_x - ys;
                n_y = i_y + xs;
                n_z = i_z - STEP_ANG;
            end else begin
                n_x = i_x + ys;
                n_y = i_y - xs;
                n_z = i_z + STEP_ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

// ===== hw/rtl/great_circle_path_points.sv =====
// ----------------------------------------------------------------------------
// great_circle_path_points
// Path points along a great circle between two positions, by vector mixing.
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) takes one segment word: start and
//   end latitude and longitude, degrees with 16 fraction bits
//   output channel (o_out_valid / i_out_ready) gives NUM_STEPS point words per
//   segment: longitude, latitude, step index, last flag on the final one
//   front end: the four angles go one a cycle, unless a stalled receiver holds
//   them, through a 24-cell sine/cosine chain; multiplier stages then build
//   the two unit vectors
//   back end: one mixed vector a cycle, unless stalled, enters a 24-cell atan2
//   chain, a gain multiplier, and a second 24-cell atan2 chain for latitude
//   throughput is one point per cycle while the receiver is ready;
//   the next segment is converted while the current one is still streaming
//   reset clears all valid flags and both stored vectors
//   a stalled receiver freezes every stage; the output register holds its word
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_path_points #(
    parameter int NUM_STEPS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [23:0]  i_from_lat,
    input  wire logic signed [24:0]  i_from_lon,
    input  wire logic signed [23:0]  i_to_lat,
    input  wire logic signed [24:0]  i_to_lon,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [24:0]       o_point_lon,
    output logic signed [23:0]       o_point_lat,
    output logic [5:0]               o_step_index,
    output logic                     o_last_point
);
    import gcp_pkg::*;

    localparam logic [5:0] LAST_IDX = 6'(NUM_STEPS - 1);
    localparam int         N        = CORDIC_ITERS;
    localparam int         A_TAG_W  = 39;
    localparam int         B_TAG_W  = 32;

    logic adv, in_acc;

    logic               r_out_valid;
    logic signed [24:0] r_out_lon;
    logic signed [23:0] r_out_lat;
    logic [5:0]         r_out_idx;
    logic               r_out_last;

    assign adv = !r_out_valid || i_out_ready;

    // feeder
    logic signed [24:0] r_ang [4];
    logic [1:0]         r_feed_cnt;
    logic               r_feed_act, r_conv_busy, r_pend_valid;
    t_ang               feed_z, fold_z;

    assign o_in_ready = !r_conv_busy && !r_pend_valid;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        feed_z = t_ang'(r_ang[r_feed_cnt]) <<< ANG_SHIFT;
        fold_z = feed_z;
        if (feed_z >= HALF_Q24) begin
            fold_z = feed_z - FULL_Q24;
        end else if (feed_z < -HALF_Q24) begin
            fold_z = feed_z + FULL_Q24;
        end
    end

    logic    r_p_go, r_p_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_act  <= 1'b0;
            r_feed_cnt  <= '0;
            r_conv_busy <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ang[SLOT_FROM_LAT] <= 25'(i_from_lat);
                r_ang[SLOT_FROM_LON] <= i_from_lon;
                r_ang[SLOT_TO_LAT]   <= 25'(i_to_lat);
                r_ang[SLOT_TO_LON]   <= i_to_lon;
                r_feed_act  <= 1'b1;
                r_feed_cnt  <= '0;
                r_conv_busy <= 1'b1;
            end else if (adv && r_feed_act) begin
                r_feed_cnt <= r_feed_cnt + 2'd1;
                if (r_feed_cnt == SLOT_TO_LON) begin
                    r_feed_act <= 1'b0;
                end
            end
            if (adv && r_p_go && r_p_end) begin
                r_conv_busy <= 1'b0;
            end
        end
    end

    // quadrant folding
    logic    r_f1_valid, r_f2_valid;
    t_ang    r_f1_z, r_f2_z, q_z;
    logic [1:0] r_f1_slot;
    t_sc_tag r_f2_tag, q_tag;

    always_comb begin
        q_z      = r_f1_z;
        q_tag    = '{neg: 1'b0, slot: r_f1_slot};
        if (r_f1_z > QUARTER_Q24) begin
            q_z       = r_f1_z - HALF_Q24;
            q_tag.neg = 1'b1;
        end else if (r_f1_z < -QUARTER_Q24) begin
            q_z       = r_f1_z + HALF_Q24;
            q_tag.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (adv) begin
            r_f1_valid <= r_feed_act;
            r_f2_valid <= r_f1_valid;
        end
        if (adv) begin
            r_f1_z    <= fold_z;
            r_f1_slot <= r_feed_cnt;
            r_f2_z    <= q_z;
            r_f2_tag  <= q_tag;
        end
    end

    // sine / cosine chain
    logic    sc_v [N+1];
    t_dat    sc_x [N+1];
    t_dat    sc_y [N+1];
    t_ang    sc_z [N+1];
    t_sc_tag sc_t [N+1];

    assign sc_v[0] = r_f2_valid;
    assign sc_x[0] = t_dat'(GAIN_Q30);
    assign sc_y[0] = '0;
    assign sc_z[0] = r_f2_z;
    assign sc_t[0] = r_f2_tag;

    for (genvar k = 0; k < N; k++) begin : g_sc
        gcp_cordic_cell #(
            .ITER      (k),
            .VECTORING (1'b0),
            .TAG_W     ($bits(t_sc_tag))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (sc_v[k]),
            .i_x     (sc_x[k]),
            .i_y     (sc_y[k]),
            .i_z     (sc_z[k]),
            .i_tag   (sc_t[k]),
            .o_valid (sc_v[k+1]),
            .o_x     (sc_x[k+1]),
            .o_y     (sc_y[k+1]),
            .o_z     (sc_z[k+1]),
            .o_tag   (sc_t[k+1])
        );
    end

    // vector build
    logic signed [31:0] sc_c, sc_s;
    logic signed [31:0] r_clat, r_slat, r_clon, r_slon, slat_rnd;
    logic               r_mul_go, r_mul_end, sc_is_lon;
    logic signed [63:0] r_p0, r_p1, p0_rnd, p1_rnd;
    t_vec               r_pz;
    t_vec               r_s_vec [3];
    t_vec               r_e_vec [3];

    assign sc_c      = 32'(sc_t[N].neg ? -sc_x[N] : sc_x[N]);
    assign sc_s      = 32'(sc_t[N].neg ? -sc_y[N] : sc_y[N]);
    assign sc_is_lon = (sc_t[N].slot == SLOT_FROM_LON) || (sc_t[N].slot == SLOT_TO_LON);
    assign slat_rnd  = (r_slat + 32'sd8192) >>> 14;
    assign p0_rnd    = r_p0 + (64'sd1 <<< 43);
    assign p1_rnd    = r_p1 + (64'sd1 <<< 43);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go <= 1'b0;
            r_p_go   <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_s_vec[j] <= '0;
                r_e_vec[j] <= '0;
            end
        end else if (adv) begin
            r_mul_go <= sc_v[N] && sc_is_lon;
            r_p_go   <= r_mul_go;
            if (r_p_go) begin
                if (r_p_end) begin
                    r_e_vec[0] <= t_vec'(p0_rnd[61:44]);
                    r_e_vec[1] <= t_vec'(p1_rnd[61:44]);
                    r_e_vec[2] <= r_pz;
                end else begin
                    r_s_vec[0] <= t_vec'(p0_rnd[61:44]);
                    r_s_vec[1] <= t_vec'(p1_rnd[61:44]);
                    r_s_vec[2] <= r_pz;
                end
            end
        end
        if (adv) begin
            if (sc_v[N]) begin
                if (sc_is_lon) begin
                    r_clon <= sc_c;
                    r_slon <= sc_s;
                end else begin
                    r_clat <= sc_c;
                    r_slat <= sc_s;
                end
            end
            r_mul_end <= (sc_t[N].slot == SLOT_TO_LON);
            r_p0      <= r_clat * r_clon;
            r_p1      <= r_clat * r_slon;
            r_pz      <= t_vec'(slat_rnd);
            r_p_end   <= r_mul_end;
        end
    end

    // point generator
    logic       r_g_valid;
    logic [5:0] r_g_i;
    t_mix       r_g_x, r_g_y, r_g_z, r_dx, r_dy, r_dz;
    logic       g_more;

    assign g_more = r_g_valid && (r_g_i != LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid    <= 1'b0;
            r_g_i        <= '0;
            r_pend_valid <= 1'b0;
        end else if (adv) begin
            if (g_more) begin
                r_g_i <= r_g_i + 6'd1;
                r_g_x <= r_g_x + r_dx;
                r_g_y <= r_g_y + r_dy;
                r_g_z <= r_g_z + r_dz;
            end else if (r_pend_valid) begin
                r_g_valid    <= 1'b1;
                r_pend_valid <= 1'b0;
                r_g_i        <= '0;
                r_g_x <= (t_mix'(r_s_vec[0]) * t_mix'(NUM_STEPS)) <<< 7;
                r_g_y <= (t_mix'(r_s_vec[1]) * t_mix'(NUM_STEPS)) <<< 7;
                r_g_z <= (t_mix'(r_s_vec[2]) * t_mix'(NUM_STEPS)) <<< 7;
                r_dx  <= (t_mix'(r_e_vec[0]) - t_mix'(r_s_vec[0])) <<< 7;
                r_dy  <= (t_mix'(r_e_vec[1]) - t_mix'(r_s_vec[1])) <<< 7;
                r_dz  <= (t_mix'(r_e_vec[2]) - t_mix'(r_s_vec[2])) <<< 7;
            end else begin
                r_g_valid <= 1'b0;
            end
            if (r_p_go && r_p_end) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    // longitude chain entry
    logic               r_a_valid;
    t_dat               r_a_x, r_a_y;
    t_ang               r_a_z;
    logic [A_TAG_W-1:0] r_a_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= r_g_valid;
        end
        if (adv) begin
            if (r_g_x < 0) begin
                r_a_x <= -t_dat'(r_g_x);
                r_a_y <= -t_dat'(r_g_y);
                r_a_z <= (r_g_y >= 0) ? HALF_Q24 : -HALF_Q24;
            end else begin
                r_a_x <= t_dat'(r_g_x);
                r_a_y <= t_dat'(r_g_y);
                r_a_z <= '0;
            end
            r_a_tag <= {r_g_z, r_g_i, (r_g_i == LAST_IDX)};
        end
    end

    logic               at_v [N+1];
    t_dat               at_x [N+1];
    t_dat               at_y [N+1];
    t_ang               at_z [N+1];
    logic [A_TAG_W-1:0] at_t [N+1];

    assign at_v[0] = r_a_valid;
    assign at_x[0] = r_a_x;
    assign at_y[0] = r_a_y;
    assign at_z[0] = r_a_z;
    assign at_t[0] = r_a_tag;

    for (genvar k = 0; k < N; k++) begin : g_at
        gcp_cordic_cell #(
            .ITER      (k),
            .VECTORING (1'b1),
            .TAG_W     (A_TAG_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (at_v[k]),
            .i_x     (at_x[k]),
            .i_y     (at_y[k]),
            .i_z     (at_z[k]),
            .i_tag   (at_t[k]),
            .o_valid (at_v[k+1]),
            .o_x     (at_x[k+1]),
            .o_y     (at_y[k+1]),
            .o_z     (at_z[k+1]),
            .o_tag   (at_t[k+1])
        );
    end

    // gain correction of the horizontal magnitude
    logic               r_m_valid;
    logic signed [65:0] r_m_prod;
    logic signed [24:0] r_m_lon;
    t_mix               r_m_z;
    logic [6:0]         r_m_il;
    t_dat               m_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= at_v[N];
        end
        if (adv) begin
            r_m_prod <= at_x[N] * GAIN_Q30;
            r_m_lon  <= to_lon(at_z[N]);
            r_m_z    <= t_mix'(at_t[N][38:7]);
            r_m_il   <= at_t[N][6:0];
        end
    end

    assign m_h = t_dat'(signed'(r_m_prod[63:30]));

    // latitude chain entry
    logic               r_b_valid;
    t_dat               r_b_x, r_b_y;
    t_ang               r_b_z;
    logic [B_TAG_W-1:0] r_b_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_m_valid;
        end
        if (adv) begin
            if (m_h < 0) begin
                r_b_x <= -m_h;
                r_b_y <= -t_dat'(r_m_z);
                r_b_z <= (r_m_z >= 0) ? HALF_Q24 : -HALF_Q24;
            end else begin
                r_b_x <= m_h;
                r_b_y <= t_dat'(r_m_z);
                r_b_z <= '0;
            end
            r_b_tag <= {r_m_lon, r_m_il};
        end
    end

    logic               bt_v [N+1];
    t_dat               bt_x [N+1];
    t_dat               bt_y [N+1];
    t_ang               bt_z [N+1];
    logic [B_TAG_W-1:0] bt_t [N+1];

    assign bt_v[0] = r_b_valid;
    assign bt_x[0] = r_b_x;
    assign bt_y[0] = r_b_y;
    assign bt_z[0] = r_b_z;
    assign bt_t[0] = r_b_tag;

    for (genvar k = 0; k < N; k++) begin : g_bt
        gcp_cordic_cell #(
            .ITER      (k),
            .VECTORING (1'b1),
            .TAG_W     (B_TAG_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (bt_v[k]),
            .i_x     (bt_x[k]),
            .i_y     (bt_y[k]),
            .i_z     (bt_z[k]),
            .i_tag   (bt_t[k]),
            .o_valid (bt_v[k+1]),
            .o_x     (bt_x[k+1]),
            .o_y     (bt_y[k+1]),
            .o_z     (bt_z[k+1]),
            .o_tag   (bt_t[k+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= bt_v[N];
        end
        if (adv) begin
            r_out_lat  <= to_lat(bt_z[N]);
            r_out_lon  <= signed'(bt_t[N][31:7]);
            r_out_idx  <= bt_t[N][6:1];
            r_out_last <= bt_t[N][0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_point_lon  = r_out_lon;
    assign o_point_lat  = r_out_lat;
    assign o_step_index = r_out_idx;
    assign o_last_point = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/gcp_checker.sv =====
// ----------------------------------------------------------------------------
// gcp_checker
// Port-level checks for the great circle path point block.
// ----------------------------------------------------------------------------
`default_nettype none

module gcp_checker #(
    parameter int NUM_STEPS = 64
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [24:0] o_point_lon,
    input wire logic signed [23:0] o_point_lat,
    input wire logic [5:0]         o_step_index,
    input wire logic               o_last_point
);

    localparam logic [5:0] LAST_IDX = 6'(NUM_STEPS - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_lon)
            && $stable(o_point_lat) && $stable(o_step_index))
        else $error("output word changed while stalled");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_point |-> o_step_index == LAST_IDX)
        else $error("last flag on wrong step");

    a_one_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("segment taken while converting");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_point_lon <= 25'sd11796480 && o_point_lon >= -25'sd11796480
            && o_point_lat <= 24'sd5898240 && o_point_lat >= -24'sd5898240)
        else $error("point out of range");

endmodule

bind great_circle_path_points gcp_checker #(.NUM_STEPS(NUM_STEPS)) u_gcp_checker (.*);

`default_nettype wire

// ===== dv/great_circle_path_points_tb.sv =====
// ----------------------------------------------------------------------------
// great_circle_path_points_tb
// Self-checking bench: random and directed segments go in, each segment's
// NUM_STEPS points are predicted in fixed point and checked word by word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module great_circle_path_points_tb;

    localparam int  N_STEPS    = 64;
    localparam int  N_RANDOM   = 465;
    localparam int  IDLE_LIMIT = 3000;
    localparam int  LONG_HOLD  = 700;
    localparam longint GAIN    = 652032874;
    localparam longint HALF    = 64'sd3019898880;
    localparam longint QUARTER = 64'sd1509949440;
    localparam longint FULL    = 64'sd6039797760;
    localparam longint LAT90   = 5898240;
    localparam longint LON180  = 11796480;
    localparam longint ATAN_TAB [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29336, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic signed [23:0] from_lat;
        logic signed [24:0] from_lon;
        logic signed [23:0] to_lat;
        logic signed [24:0] to_lon;
        int                 gap;
        bit                 drain;
    } t_segment;

    typedef struct {
        logic signed [24:0] lon;
        logic signed [23:0] lat;
        logic [5:0]         idx;
        logic               last;
    } t_point;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [23:0] i_from_lat = '0;
    logic signed [24:0] i_from_lon = '0;
    logic signed [23:0] i_to_lat = '0;
    logic signed [24:0] i_to_lon = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [24:0] o_point_lon;
    logic signed [23:0] o_point_lat;
    logic [5:0]         o_step_index;
    logic               o_last_point;

    t_segment pending_segs[$];
    t_point   expected_points[$];
    int       n_errors = 0;
    int       n_segs_in = 0;
    int       idle_cycles = 0;
    int       gap_count = 0;
    int       stall_count = 0;
    int       hold_count = 0;
    bit       hold_done = 1'b0;
    bit       stall_free = 1'b0;

    great_circle_path_points u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_from_lat   (i_from_lat),
        .i_from_lon   (i_from_lon),
        .i_to_lat     (i_to_lat),
        .i_to_lon     (i_to_lon),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_point_lon  (o_point_lon),
        .o_point_lat  (o_point_lat),
        .o_step_index (o_step_index),
        .o_last_point (o_last_point)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // sine and cosine in q30 of an angle in degrees q16
    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint z, x, y, nx, ny;
        bit neg;
        z = (ang * 256) % FULL;
        x = GAIN;
        y = 0;
        neg = 1'b0;
        if (z >= HALF) z -= FULL;
        else if (z < -HALF) z += FULL;
        if (z > QUARTER) begin
            z -= HALF;
            neg = 1'b1;
        end else if (z < -QUARTER) begin
            z += HALF;
            neg = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_TAB[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    // vector angle in degrees q24, gain-scaled magnitude alongside
    task automatic vec_angle(input longint xi, input longint yi, output longint z,
                             output longint mag);
        longint x, y, nx, ny;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF : -HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 24; i++) begin
            nx = x;
            ny = y;
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_TAB[i];
            end else if (y < 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        mag = x;
    endtask

    function automatic longint deg_out(input longint z, input longint lim);
        longint v;
        v = (z + 128) >>> 8;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    task automatic unit_vec(input longint lat, input longint lon, output longint vx,
                            output longint vy, output longint vz);
        longint clat, slat, clon, slon;
        sin_cos(lat, clat, slat);
        sin_cos(lon, clon, slon);
        vx = longint'(int'((clat * clon + (64'sd1 <<< 43)) >>> 44));
        vy = longint'(int'((clat * slon + (64'sd1 <<< 43)) >>> 44));
        vz = longint'(int'((slat + (64'sd1 <<< 13)) >>> 14));
    endtask

    task automatic predict_path(input t_segment sg);
        longint ax, ay, az, bx, by, bz, x, y, z, lon, lat, mag, h, zl, junk;
        t_point p;
        unit_vec(sg.from_lat, sg.from_lon, ax, ay, az);
        unit_vec(sg.to_lat, sg.to_lon, bx, by, bz);
        for (int i = 0; i < N_STEPS; i++) begin
            x = ((N_STEPS - i) * ax + i * bx) * 128;
            y = ((N_STEPS - i) * ay + i * by) * 128;
            z = ((N_STEPS - i) * az + i * bz) * 128;
            lon = 0;
            lat = 0;
            if (x != 0 || y != 0 || z != 0) begin
                vec_angle(x, y, zl, mag);
                lon = deg_out(zl, LON180);
                h = (mag * GAIN) >>> 30;
                vec_angle(h, z, zl, junk);
                lat = deg_out(zl, LAT90);
            end
            p.lon = lon[24:0];
            p.lat = lat[23:0];
            p.idx = 6'(i);
            p.last = (i == N_STEPS - 1);
            expected_points.push_back(p);
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    endtask

    task automatic add_seg(input longint la0, input longint lo0, input longint la1,
                           input longint lo1, input int gap, input bit drain);
        t_segment sg;
        sg.from_lat = 24'(la0);
        sg.from_lon = 25'(lo0);
        sg.to_lat = 24'(la1);
        sg.to_lon = 25'(lo1);
        sg.gap = gap;
        sg.drain = drain;
        pending_segs.push_back(sg);
    endtask

    function automatic longint rand_ang(input longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_path('{i_from_lat, i_from_lon, i_to_lat, i_to_lon, 0, 1'b0});
                n_segs_in++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_segs.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (gap_count < pending_segs[0].gap ||
                             (pending_segs[0].drain && expected_points.size() != 0)) begin
                    if (gap_count < pending_segs[0].gap) gap_count++;
                    i_in_valid <= 1'b0;
                end else begin
                    gap_count = 0;
                    i_from_lat <= pending_segs[0].from_lat;
                    i_from_lon <= pending_segs[0].from_lon;
                    i_to_lat <= pending_segs[0].to_lat;
                    i_to_lon <= pending_segs[0].to_lon;
                    i_in_valid <= 1'b1;
                    void'(pending_segs.pop_front());
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    p = expected_points.pop_front();
                    if (o_point_lon !== p.lon) report("point_lon", o_point_lon, p.lon);
                    if (o_point_lat !== p.lat) report("point_lat", o_point_lat, p.lat);
                    if (o_step_index !== p.idx) report("step_index", o_step_index, p.idx);
                    if (o_last_point !== p.last) report("last_point", o_last_point, p.last);
                    if (p.last) stall_free = ($urandom_range(3) == 0);
                end
                stall_count = stall_free ? 0 : $urandom_range(8);
            end
            if (!hold_done && n_segs_in == 120) begin
                hold_done = 1'b1;
                hold_count = LONG_HOLD;
            end
            if (hold_count > 0) begin
                hold_count--;
                i_out_ready <= 1'b0;
            end else if (stall_count > 0) begin
                stall_count--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("great_circle_path_points_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int  g;
        bit  burst;
        // extremes, repeated points, poles, antipodes, dateline
        add_seg(0, 0, 0, 0, 0, 0);
        add_seg(LAT90, LON180, -LAT90, -LON180, 0, 0);
        add_seg(-LAT90, 0, LAT90, 0, 0, 0);
        add_seg(0, 0, 0, LON180, 0, 0);
        add_seg(0, 0, 0, -LON180, 0, 0);
        add_seg(0, LON180, 0, LON180, 0, 0);
        add_seg(0, -LON180, 0, -LON180, 0, 0);
        add_seg(LAT90, 0, LAT90, 12345, 0, 0);
        add_seg(-LAT90, 0, -LAT90, -LON180, 0, 0);
        add_seg(LAT90 / 2, LON180 / 2, -LAT90 / 2, -LON180 / 2, 0, 0);
        add_seg(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1, 0, 0);
        add_seg((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24), 3, 0);
        add_seg(-1, -1, 1, 1, 0, 0);
        add_seg(LAT90 + 65536, 0, -LAT90 - 65536, LON180, 0, 0);
        add_seg(2949120, 7864320, -2949120, -3932160, 8, 0);
        add_seg(0, LON180 - 1, 0, -LON180 + 1, 0, 0);
        burst = 1'b0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(15) == 0) burst = ~burst;
            g = burst ? 0 : $urandom_range(8);
            if ($urandom_range(7) == 0)
                add_seg(longint'($signed(24'($urandom))), longint'($signed(25'($urandom))),
                        longint'($signed(24'($urandom))), longint'($signed(25'($urandom))),
                        g, k == 300);
            else
                add_seg(rand_ang(LAT90), rand_ang(LON180), rand_ang(LAT90),
                        rand_ang(LON180), g, k == 300);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_segs.size() != 0 || i_in_valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0)
            $display("great_circle_path_points_tb: PASS");
        else
            $display("great_circle_path_points_tb: FAIL");
        $finish;
    end

endmodule
